### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BDAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BDAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bdau_pkg.sv
// Types and codes of the decimal accumulator unit.
package bdau_pkg;

  localparam int unsigned FIELD_W = 64;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_REM  = 3'd5;

  localparam logic [2:0] ERR_OK   = 3'd0;
  localparam logic [2:0] ERR_SUM  = 3'd1;
  localparam logic [2:0] ERR_NEG  = 3'd2;
  localparam logic [2:0] ERR_PROD = 3'd3;
  localparam logic [2:0] ERR_DIV0 = 3'd4;

  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [FIELD_W-1:0] operand_bcd;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_bcd;
    logic [2:0]         error_code;
    logic [1:0]         compare_code;
    logic               result_is_zero;
  } out_t;

  // Status of the sequencer as seen by the top level.
  typedef struct packed {
    logic       ready;
    logic       done;
    logic [2:0] err;
    logic [1:0] cmp;
  } seq_stat_t;

endpackage

### rtl/core/bdau_digit.sv
// One BCD digit of addition or subtraction with carry or borrow.
module bdau_digit (
  input  logic       sub,
  input  logic [3:0] dx,
  input  logic [3:0] dy,
  input  logic       ci,
  output logic [3:0] dz,
  output logic       co
);

  logic [4:0] s;
  logic [4:0] s_fix;

  always_comb begin
    if (sub) begin
      s = {1'b0, dx} - {1'b0, dy} - {4'd0, ci};
      s_fix = s + 5'd10;
      co = s[4];
      dz = s[4] ? s_fix[3:0] : s[3:0];
    end else begin
      s = {1'b0, dx} + {1'b0, dy} + {4'd0, ci};
      s_fix = s - 5'd10;
      co = (s > 5'd9);
      dz = co ? s_fix[3:0] : s[3:0];
    end
  end

endmodule

### rtl/core/bdau_seq.sv
// Digit-serial sequencer: accumulator, working shift registers and command control.
module bdau_seq #(
  parameter int DIGITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0]            cmd,
  input  logic [4*DIGITS-1:0]   operand,
  input  logic                  take,
  output bdau_pkg::seq_stat_t   stat,
  output logic [4*DIGITS-1:0]   res
);

  localparam int W   = DIGITS + 1;
  localparam int XW  = 4 * W;
  localparam int AW  = 4 * DIGITS;
  localparam int PCW = $clog2(W);
  localparam int OCW = $clog2(DIGITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [1:0] PH_CMP = 2'd0;
  localparam logic [1:0] PH_ADD = 2'd1;
  localparam logic [1:0] PH_MUL = 2'd2;
  localparam logic [1:0] PH_DIV = 2'd3;

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     ph_r, ph_nxt;
  logic [2:0]     cmd_r, cmd_nxt;
  logic [AW-1:0]  opb_r, opb_nxt;
  logic           bz_r, bz_nxt;
  logic [XW-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [AW-1:0]  aux_r, aux_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic [OCW-1:0] oc_r, oc_nxt;
  logic [3:0]     rep_r, rep_nxt;
  logic           c_r, c_nxt;
  logic           zz_r, zz_nxt;
  logic [1:0]     cmp_r, cmp_nxt;
  logic [2:0]     err_r, err_nxt;
  logic [AW-1:0]  res_r, res_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;

  logic [AW-1:0]  opb_in;
  logic           d_sub;
  logic [3:0]     d_z;
  logic           d_co;

  // Digits above nine count as zero.
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      opb_in[4*k +: 4] = (operand[4*k +: 4] > 4'd9) ? 4'd0 : operand[4*k +: 4];
    end
  end

  assign d_sub = (ph_r == PH_CMP) || (ph_r == PH_DIV);

  bdau_digit u_digit (
    .sub (d_sub),
    .dx  (x_r[3:0]),
    .dy  (y_r[3:0]),
    .ci  (c_r),
    .dz  (d_z),
    .co  (d_co)
  );

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd_nxt   = cmd_r;
    opb_nxt   = opb_r;
    bz_nxt    = bz_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    aux_nxt   = aux_r;
    pc_nxt    = pc_r;
    oc_nxt    = oc_r;
    rep_nxt   = rep_r;
    c_nxt     = c_r;
    zz_nxt    = zz_r;
    cmp_nxt   = cmp_r;
    err_nxt   = err_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          opb_nxt   = opb_in;
          bz_nxt    = (opb_in == '0);
          x_nxt     = {4'd0, acc_r};
          y_nxt     = {4'd0, opb_in};
          ph_nxt    = PH_CMP;
          pc_nxt    = '0;
          c_nxt     = 1'b0;
          zz_nxt    = 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        // Rotate both operands one digit; the result digit enters from the top.
        x_nxt  = {x_r[3:0], x_r[XW-1:4]};
        y_nxt  = {y_r[3:0], y_r[XW-1:4]};
        z_nxt  = {d_z, z_r[XW-1:4]};
        c_nxt  = d_co;
        zz_nxt = zz_r & (d_z == 4'd0);
        if (pc_r == PCW'(W - 1)) begin
          state_nxt = S_EVAL;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_EVAL: begin
        pc_nxt = '0;
        c_nxt  = 1'b0;
        zz_nxt = 1'b1;
        case (ph_r)
          PH_CMP: begin
            cmp_nxt = c_r ? bdau_pkg::CMP_LESS
                          : (zz_r ? bdau_pkg::CMP_EQUAL : bdau_pkg::CMP_GREATER);
            err_nxt = bdau_pkg::ERR_OK;
            res_nxt = acc_r;
            state_nxt = S_FIN;
            case (cmd_r)
              bdau_pkg::CMD_LOAD: res_nxt = opb_r;
              bdau_pkg::CMD_ADD: begin
                ph_nxt    = PH_ADD;
                state_nxt = S_PASS;
              end
              bdau_pkg::CMD_SUB: begin
                if (c_r) begin
                  err_nxt = bdau_pkg::ERR_NEG;
                end else begin
                  res_nxt = z_r[AW-1:0];
                end
              end
              bdau_pkg::CMD_MUL: begin
                x_nxt     = '0;
                y_nxt     = {4'd0, acc_r};
                aux_nxt   = opb_r;
                oc_nxt    = '0;
                ph_nxt    = PH_MUL;
                state_nxt = S_STEP;
              end
              bdau_pkg::CMD_DIV, bdau_pkg::CMD_REM: begin
                if (bz_r) begin
                  err_nxt = bdau_pkg::ERR_DIV0;
                end else begin
                  x_nxt     = '0;
                  aux_nxt   = acc_r;
                  oc_nxt    = '0;
                  ph_nxt    = PH_DIV;
                  state_nxt = S_STEP;
                end
              end
              default: res_nxt = acc_r;
            endcase
          end
          PH_ADD: begin
            state_nxt = S_FIN;
            if (z_r[XW-1 -: 4] != 4'd0) begin
              err_nxt = bdau_pkg::ERR_SUM;
            end else begin
              res_nxt = z_r[AW-1:0];
            end
          end
          PH_MUL: begin
            if (z_r[XW-1 -: 4] != 4'd0) begin
              err_nxt   = bdau_pkg::ERR_PROD;
              state_nxt = S_FIN;
            end else begin
              x_nxt   = z_r;
              rep_nxt = rep_r - 4'd1;
              state_nxt = (rep_r == 4'd1) ? S_STEP : S_PASS;
            end
          end
          default: begin
            // Trial subtraction of the divisor; a borrow ends this quotient digit.
            if (c_r) begin
              state_nxt = S_STEP;
            end else begin
              x_nxt        = z_r;
              aux_nxt[3:0] = aux_r[3:0] + 4'd1;
              state_nxt    = S_PASS;
            end
          end
        endcase
      end
      S_STEP: begin
        pc_nxt = '0;
        c_nxt  = 1'b0;
        zz_nxt = 1'b1;
        if (oc_r == OCW'(DIGITS)) begin
          state_nxt = S_FIN;
          if (ph_r == PH_MUL) begin
            res_nxt = x_r[AW-1:0];
          end else if (cmd_r == bdau_pkg::CMD_DIV) begin
            res_nxt = aux_r;
          end else begin
            res_nxt = x_r[AW-1:0];
          end
        end else if (ph_r == PH_MUL) begin
          if (x_r[AW-1 -: 4] != 4'd0) begin
            err_nxt   = bdau_pkg::ERR_PROD;
            state_nxt = S_FIN;
          end else begin
            x_nxt     = {x_r[XW-5:0], 4'd0};
            rep_nxt   = aux_r[AW-1 -: 4];
            aux_nxt   = {aux_r[AW-5:0], 4'd0};
            oc_nxt    = oc_r + 1'b1;
            state_nxt = (aux_r[AW-1 -: 4] == 4'd0) ? S_STEP : S_PASS;
          end
        end else begin
          // Bring down the next dividend digit; the quotient digit grows at the bottom.
          x_nxt     = {x_r[XW-5:0], aux_r[AW-1 -: 4]};
          aux_nxt   = {aux_r[AW-5:0], 4'd0};
          oc_nxt    = oc_r + 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_FIN: begin
        if (take) begin
          if (err_r == bdau_pkg::ERR_OK) begin
            acc_nxt = res_r;
          end else begin
            res_nxt = acc_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
    ph_r  <= ph_nxt;
    cmd_r <= cmd_nxt;
    opb_r <= opb_nxt;
    bz_r  <= bz_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    aux_r <= aux_nxt;
    pc_r  <= pc_nxt;
    oc_r  <= oc_nxt;
    rep_r <= rep_nxt;
    c_r   <= c_nxt;
    zz_r  <= zz_nxt;
    cmp_r <= cmp_nxt;
    err_r <= err_nxt;
    res_r <= res_nxt;
  end

  assign stat.ready = (state_r == S_IDLE);
  assign stat.done  = (state_r == S_FIN);
  assign stat.err   = err_r;
  assign stat.cmp   = cmp_r;
  assign res = (err_r == bdau_pkg::ERR_OK) ? res_r : acc_r;

endmodule

### rtl/core/bcd_decimal_accumulator_alu_top.sv
// Top level: handshakes, result register and the digit-serial sequencer.
// Each command runs digit-serially through the one-digit adder: load, subtract and unknown
// codes take a compare pass, add a compare pass and an add pass, and multiply, divide and
// remainder a compare pass, then repeated add or trial-subtract passes for each digit.
// One item at a time: in_stall drops as the result enters the output register.
// Synchronous active-low reset clears the accumulator to zero and empties the output.
module bcd_decimal_accumulator_alu_top #(
  parameter int DIGITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bdau_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bdau_pkg::out_t out_data
);

  bdau_pkg::seq_stat_t  stat;
  logic [4*DIGITS-1:0]  seq_res;
  logic                 take;
  logic                 out_valid_r, out_valid_nxt;
  bdau_pkg::out_t       out_r, out_nxt;

  assign in_stall = !stat.ready;
  assign take = stat.done && (!out_valid_r || !out_stall);

  bdau_seq #(.DIGITS(DIGITS)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid && stat.ready),
    .cmd     (in_data.cmd),
    .operand (in_data.operand_bcd[4*DIGITS-1:0]),
    .take    (take),
    .stat    (stat),
    .res     (seq_res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_nxt.result_bcd     = bdau_pkg::FIELD_W'(seq_res);
      out_nxt.error_code     = stat.err;
      out_nxt.compare_code   = stat.cmp;
      out_nxt.result_is_zero = (seq_res == '0);
      out_valid_nxt          = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/bdau_chk.sv
// Port-level checker for the decimal accumulator unit, bound to the top level.
`include "assert_macros.svh"

module bdau_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input bdau_pkg::out_t out_data,
  input logic           out_valid,
  input logic           out_stall
);

  `BDAU_ASSERT(a_out_hold, (out_valid && out_stall |=> out_valid && $stable(out_data)), "stalled result beat changed")
  `BDAU_ASSERT(a_zero_flag, (out_valid |-> out_data.result_is_zero == (out_data.result_bcd == '0)), "zero flag disagrees with result")
  `BDAU_ASSERT(a_neg_less, (out_valid && out_data.error_code == bdau_pkg::ERR_NEG |-> out_data.compare_code == bdau_pkg::CMP_LESS), "negative difference without less compare")
  `BDAU_ASSERT(a_in_after_out, (out_valid && out_stall && !in_stall |=> in_stall || !in_valid || out_valid), "output dropped while stalled")

endmodule

bind bcd_decimal_accumulator_alu_top bdau_chk u_bdau_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

### bench/tb_bcd_decimal_accumulator_alu_top.sv
// Self-checking bench for the decimal accumulator unit with a built-in predictor.
`timescale 1ns / 1ps

module tb_bcd_decimal_accumulator_alu_top;

  localparam int DIGITS = 16;
  localparam int NUM_RANDOM = 930;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bdau_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  bdau_pkg::out_t out_data;

  bcd_decimal_accumulator_alu_top #(.DIGITS(DIGITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  bdau_pkg::in_t  pending_items[$];
  bdau_pkg::out_t expected_results[$];
  logic [63:0] acc_model;
  int mismatch_count;
  int burst_left;
  int gap_left;
  bit drain_request;
  bit stimulus_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Max value that fits in the accumulator.
  function automatic logic [63:0] acc_limit();
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < DIGITS; i++) v = v * 64'd10;
    return v - 64'd1;
  endfunction

  function automatic logic [63:0] bcd_to_bin(logic [63:0] bcd);
    logic [63:0] v;
    logic [3:0] d;
    v = '0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      d = bcd[4*i +: 4];
      if (d > 4'd9) d = 4'd0;
      v = v * 64'd10 + {60'd0, d};
    end
    return v;
  endfunction

  function automatic logic [63:0] bin_to_bcd(logic [63:0] v);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < DIGITS; i++) begin
      p[4*i +: 4] = 4'(v % 64'd10);
      v = v / 64'd10;
    end
    return p;
  endfunction

  // Computes the result of one command and advances the model accumulator.
  function automatic bdau_pkg::out_t accumulate(bdau_pkg::in_t item);
    bdau_pkg::out_t res;
    logic [63:0] a, b, r, lim;
    logic [2:0] err;
    a = acc_model;
    b = bcd_to_bin(item.operand_bcd);
    lim = acc_limit();
    r = a;
    err = bdau_pkg::ERR_OK;
    case (item.cmd)
      bdau_pkg::CMD_LOAD: r = b;
      bdau_pkg::CMD_ADD: if (a + b > lim) err = bdau_pkg::ERR_SUM; else r = a + b;
      bdau_pkg::CMD_SUB: if (a < b) err = bdau_pkg::ERR_NEG; else r = a - b;
      bdau_pkg::CMD_MUL: if (b != 0 && a > lim / b) err = bdau_pkg::ERR_PROD; else r = a * b;
      bdau_pkg::CMD_DIV: if (b == 0) err = bdau_pkg::ERR_DIV0; else r = a / b;
      bdau_pkg::CMD_REM: if (b == 0) err = bdau_pkg::ERR_DIV0; else r = a % b;
      default: ;
    endcase
    if (err == bdau_pkg::ERR_OK) acc_model = r;
    res.result_bcd = bin_to_bcd(acc_model);
    res.error_code = err;
    res.compare_code = (a < b) ? bdau_pkg::CMP_LESS
                               : ((a == b) ? bdau_pkg::CMP_EQUAL : bdau_pkg::CMP_GREATER);
    res.result_is_zero = (acc_model == 0);
    return res;
  endfunction

  function automatic logic [63:0] random_bcd(int ndig);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < ndig; i++) p[4*i +: 4] = 4'($urandom_range(9));
    return p;
  endfunction

  function automatic bdau_pkg::in_t random_item();
    bdau_pkg::in_t it;
    int sel;
    sel = $urandom_range(99);
    it.cmd = 3'($urandom_range(5));
    if (sel < 3) it.cmd = 3'($urandom_range(7, 6));
    if (sel < 8) it.operand_bcd = {$urandom, $urandom};
    else if (sel < 14) it.operand_bcd = '0;
    else if (it.cmd == bdau_pkg::CMD_MUL || it.cmd == bdau_pkg::CMD_DIV ||
             it.cmd == bdau_pkg::CMD_REM)
      it.operand_bcd = random_bcd($urandom_range(1, 4));
    else
      it.operand_bcd = random_bcd($urandom_range(1, 16));
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_item(logic [2:0] cmd, logic [63:0] operand);
    bdau_pkg::in_t it;
    it.cmd = cmd;
    it.operand_bcd = operand;
    pending_items = {pending_items, it};
  endtask

  initial begin
    logic [63:0] nines;
    nines = 64'h9999_9999_9999_9999;
    queue_item(bdau_pkg::CMD_LOAD, nines);
    queue_item(bdau_pkg::CMD_ADD, 64'h1);
    queue_item(bdau_pkg::CMD_MUL, 64'h2);
    queue_item(bdau_pkg::CMD_MUL, 64'h0);
    queue_item(bdau_pkg::CMD_LOAD, nines);
    queue_item(bdau_pkg::CMD_MUL, 64'h1);
    queue_item(bdau_pkg::CMD_DIV, 64'h0);
    queue_item(bdau_pkg::CMD_REM, 64'h0);
    queue_item(bdau_pkg::CMD_DIV, 64'h3);
    queue_item(bdau_pkg::CMD_REM, 64'h7);
    queue_item(bdau_pkg::CMD_SUB, nines);
    queue_item(bdau_pkg::CMD_SUB, 64'h5);
    queue_item(bdau_pkg::CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(bdau_pkg::CMD_LOAD, 64'hA1B2_C3D4_E5F6_7989);
    queue_item(bdau_pkg::CMD_ADD, 64'h1234_5678_9012_3456);
    queue_item(bdau_pkg::CMD_SUB, 64'h1234_5678_9012_3456);
    queue_item(3'd6, 64'h5);
    queue_item(3'd7, 64'h0);
    queue_item(bdau_pkg::CMD_LOAD, 64'h0);
    queue_item(bdau_pkg::CMD_DIV, 64'h9);
    queue_item(bdau_pkg::CMD_ADD, nines);
    queue_item(bdau_pkg::CMD_LOAD, 64'h1);
    for (int i = 0; i < NUM_RANDOM; i++) pending_items = {pending_items, random_item()};
  end

  // Sender: bursts and gaps; one hold-off until all results are back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      drain_request <= 1'b0;
      stimulus_done <= 1'b0;
      acc_model = '0;
    end else begin
      logic take_next;
      take_next = !in_valid || !in_stall;
      if (in_valid && !in_stall) expected_results = {expected_results, accumulate(in_data)};
      if (take_next) begin
        if (pending_items.size() == NUM_RANDOM / 2 && !drain_request) begin
          drain_request <= 1'b1;
          in_valid <= 1'b0;
        end else if (drain_request && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(8, 1);
            gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall pattern plus result checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(7) < 3);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_data.result_bcd, '0);
        end else begin
          bdau_pkg::out_t want;
          want = expected_results.pop_front();
          if (out_data.result_bcd !== want.result_bcd)
            report_mismatch("result_bcd", out_data.result_bcd, want.result_bcd);
          if (out_data.error_code !== want.error_code)
            report_mismatch("error_code", 64'(out_data.error_code), 64'(want.error_code));
          if (out_data.compare_code !== want.compare_code)
            report_mismatch("compare_code", 64'(out_data.compare_code),
                            64'(want.compare_code));
          if (out_data.result_is_zero !== want.result_is_zero)
            report_mismatch("result_is_zero", 64'(out_data.result_is_zero),
                            64'(want.result_is_zero));
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("bcd_decimal_accumulator_alu_top regression: pass");
    else
      $display("bcd_decimal_accumulator_alu_top regression: fail");
    $finish;
  end

  // Timeout that ends the run as a fail if it has not finished in time.
  initial begin
    #200ms;
    $display("bcd_decimal_accumulator_alu_top regression: fail");
    $finish;
  end

endmodule
